@@ rtl/twsum_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twsum_pkg
// Shared types, register indexes and pixel gating functions for the
// thresholded 3x3 window sum.
// ----------------------------------------------------------------------------
package twsum_pkg;

  // Pixel and result widths.
  localparam int PIX_W = 8;
  localparam int SUM_W = 12;
  localparam int COL_SUM_W = 10;

  // Two stored window columns sit to the left of the incoming column.
  localparam int NUM_CELLS = 2;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_WIDTH     = 2'd1;
  localparam logic [1:0] REG_HEIGHT    = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [7:0]  THRESHOLD_RST = 8'd1;
  localparam logic [10:0] WIDTH_RST     = 11'd640;
  localparam logic [12:0] HEIGHT_RST    = 13'd480;

  // One vertical column of the 3x3 window.
  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } column_t;

  // A pixel counts only when it is at or above the threshold.
  function automatic logic [PIX_W-1:0] gate(input logic [PIX_W-1:0] v,
                                            input logic [PIX_W-1:0] thr);
    return (v >= thr) ? v : '0;
  endfunction

  // Gated sum of the three pixels of one column.
  function automatic logic [COL_SUM_W-1:0] col_sum(input column_t col,
                                                   input logic [PIX_W-1:0] thr);
    return COL_SUM_W'(gate(col.top, thr)) + COL_SUM_W'(gate(col.mid, thr))
         + COL_SUM_W'(gate(col.bot, thr));
  endfunction

endpackage

@@ rtl/twsum_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twsum_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module twsum_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/twsum_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twsum_cell
// One window column cell. It holds a column of three pixels, passes it on
// to its neighbor on every transfer and adds its gated sum to the running
// partial sum of the chain.
// ----------------------------------------------------------------------------
module twsum_cell (
  input  logic                                clk,
  input  logic                                advance,
  input  logic [twsum_pkg::PIX_W-1:0]         threshold,
  input  twsum_pkg::column_t                  col_in,
  input  logic [twsum_pkg::SUM_W-1:0]         sum_in,
  output twsum_pkg::column_t                  col_out,
  output logic [twsum_pkg::SUM_W-1:0]         sum_out
);
  import twsum_pkg::*;

  column_t col;

  // Shift the column in from the left neighbor.
  always_ff @(posedge clk) begin
    if (advance) begin
      col <= col_in;
    end
  end

  assign col_out = col;

  // Gate at use so that a new threshold applies to stored pixels too.
  assign sum_out = sum_in + SUM_W'(col_sum(col, threshold));

endmodule

@@ rtl/thresholded_window_sum_3x3_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thresholded_window_sum_3x3_top
// Thresholded 3x3 window sum over a raster-order grey pixel stream.
//
//   Channel  Direction  Handshake          Payload
//   input    in         in_valid/in_ready  pixel
//   output   out        out_valid/out_ready window_sum, center_row,
//                                           center_col, frame_end
//   config   in         APB write/read     threshold, image_width,
//                                           image_height
//
// One pixel is taken per cycle; its result, if any, is shown in the output
// register on the next cycle. The line-store RAM is read ahead at the next
// pixel's column, so the first transfer is taken in the cycle after reset
// is released. A new pixel is taken while a result waits, as long as
// that result is taken in the same cycle. Reset clears the counters and
// the output valid; the line stores hold whatever they hold until written.
// ----------------------------------------------------------------------------
module thresholded_window_sum_3x3_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic        clk,
  input  logic        rst,
  // Pixel input.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  pixel,
  // Result output.
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] window_sum,
  output logic [11:0] center_row,
  output logic [9:0]  center_col,
  output logic        frame_end,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import twsum_pkg::*;

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int WCMP = (CW + 1 > 11) ? CW + 1 : 11;
  localparam int HCMP = (RW + 1 > 13) ? RW + 1 : 13;

  // Configuration registers.
  logic [7:0]  threshold;
  logic [10:0] image_width;
  logic [12:0] image_height;
  logic        cfg_write;

  // Position counters and read-ahead flag.
  logic [CW-1:0] col_count;
  logic [CW-1:0] col_count_next;
  logic [RW-1:0] row_count;
  logic          primed;

  logic [WCMP-1:0] w_ext;
  logic [WCMP-1:0] w_eff;
  logic [HCMP-1:0] h_ext;
  logic [HCMP-1:0] h_eff;
  logic            row_last;
  logic            frame_last_row;
  logic            accept;
  logic            res_hit;

  logic [15:0] ram_rdata;
  column_t     col_new;

  column_t          chain_col [NUM_CELLS+1];
  logic [SUM_W-1:0] chain_sum [NUM_CELLS+1];

  logic [RW-1:0] row_m1;
  logic [CW-1:0] col_m1;

  // APB register port; writes complete in the access cycle.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= THRESHOLD_RST;
      image_width  <= WIDTH_RST;
      image_height <= HEIGHT_RST;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_THRESHOLD: threshold    <= pwdata[7:0];
        REG_WIDTH:     image_width  <= pwdata[10:0];
        REG_HEIGHT:    image_height <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_THRESHOLD: prdata = 32'(threshold);
      REG_WIDTH:     prdata = 32'(image_width);
      REG_HEIGHT:    prdata = 32'(image_height);
      default:       prdata = '0;
    endcase
  end

  // Effective geometry, saturated to the supported range.
  assign w_ext = WCMP'(image_width);
  assign h_ext = HCMP'(image_height);

  always_comb begin
    if (w_ext < WCMP'(3)) begin
      w_eff = WCMP'(3);
    end else if (w_ext > WCMP'(MAX_WIDTH)) begin
      w_eff = WCMP'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    if (h_ext < HCMP'(3)) begin
      h_eff = HCMP'(3);
    end else if (h_ext > HCMP'(MAX_HEIGHT)) begin
      h_eff = HCMP'(MAX_HEIGHT);
    end else begin
      h_eff = h_ext;
    end
  end

  assign row_last       = WCMP'(col_count) >= (w_eff - WCMP'(1));
  assign frame_last_row = HCMP'(row_count) >= (h_eff - HCMP'(1));

  // Handshake: take a pixel when the output register is free or drains now.
  assign in_ready = primed && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;
  assign res_hit  = (row_count >= RW'(2)) && (col_count >= CW'(2));

  // Column of the next pixel; it also addresses the read-ahead.
  always_comb begin
    col_count_next = col_count;
    if (accept) begin
      col_count_next = row_last ? '0 : col_count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      primed    <= 1'b0;
    end else begin
      primed    <= 1'b1;
      col_count <= col_count_next;
      if (accept && row_last) begin
        row_count <= frame_last_row ? '0 : row_count + RW'(1);
      end
    end
  end

  // Both line stores in one RAM: upper byte is the row two above,
  // lower byte the row just above.
  twsum_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (accept),
    .waddr (col_count),
    .wdata ({ram_rdata[PIX_W-1:0], pixel}),
    .raddr (col_count_next),
    .rdata (ram_rdata)
  );

  // Incoming column feeds the head of the cell chain.
  assign col_new.top = ram_rdata[2*PIX_W-1:PIX_W];
  assign col_new.mid = ram_rdata[PIX_W-1:0];
  assign col_new.bot = pixel;

  assign chain_col[0] = col_new;
  assign chain_sum[0] = SUM_W'(col_sum(col_new, threshold));

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    twsum_cell u_cell (
      .clk       (clk),
      .advance   (accept),
      .threshold (threshold),
      .col_in    (chain_col[k]),
      .sum_in    (chain_sum[k]),
      .col_out   (chain_col[k+1]),
      .sum_out   (chain_sum[k+1])
    );
  end

  // Output register.
  assign row_m1 = row_count - RW'(1);
  assign col_m1 = col_count - CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= res_hit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_hit) begin
      window_sum <= chain_sum[NUM_CELLS];
      center_row <= 12'(row_m1);
      center_col <= 10'(col_m1);
      frame_end  <= row_last && frame_last_row;
    end
  end

  // A pixel with an interior center always leaves a result behind.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept && res_hit |=> out_valid)
    else $error("result missing after interior pixel");

  // A held result blocks the input.
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("pixel taken while result is held");

  // The last pixel of a frame returns both counters to the origin.
  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    accept && row_last && frame_last_row |=> col_count == '0 && row_count == '0)
    else $error("counters did not wrap at frame end");

  // The column never leaves the line store.
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    32'(col_count) < MAX_WIDTH)
    else $error("column count beyond line store");

  // No input before the read-ahead holds data.
  a_primed: assert property (@(posedge clk) disable iff (rst)
    accept |-> $past(!rst))
    else $error("pixel taken right after reset");

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the thresholded 3x3 window sum.
//
// A small scoreboard class keeps its own copy of the two line stores, the
// window cells, the row and column counters and the three registers. It
// predicts the result of every pixel transfer, and every result transfer is
// compared field by field with the oldest prediction. Directed 3x3 frames
// cover the pixel extremes, the threshold edge and register saturation.
// One frame at the widest random width fills the first columns of both line
// stores, then many small random frames follow, some with register changes
// in mid-frame that stay within those columns. Both channels idle at random,
// and the result side holds off now and then long enough to back up the
// pixel input.
// ----------------------------------------------------------------------------
module tb;
  import twsum_pkg::*;

  localparam int LINE_DEPTH    = 1024;
  localparam int ROW_LIMIT     = 4096;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_PIXELS = 900;
  localparam int DRAIN_CYCLES  = 4;
  localparam int HOLD_CYCLES   = 64;
  localparam int WARM_WIDTH    = 12;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // One predicted result transfer.
  typedef struct {
    bit [11:0] window_sum;
    bit [11:0] center_row;
    bit [9:0]  center_col;
    bit        frame_end;
  } window_result_t;

  // Predictor of the window sums plus the queue of results still due.
  class window_scoreboard;
    bit [7:0]       threshold;
    bit [10:0]      width_reg;
    bit [12:0]      height_reg;
    bit [7:0]       upper_line [LINE_DEPTH];
    bit [7:0]       middle_line [LINE_DEPTH];
    bit [7:0]       cells [6];
    int unsigned    column_count;
    int unsigned    row_count;
    int unsigned    pixels_taken;
    int unsigned    errors;
    window_result_t predicted_windows [$];

    function new();
      threshold    = THRESHOLD_RST;
      width_reg    = WIDTH_RST;
      height_reg   = HEIGHT_RST;
      column_count = 0;
      row_count    = 0;
      pixels_taken = 0;
      errors       = 0;
    endfunction

    function int unsigned bounded(int unsigned v, int unsigned lo, int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    // A pixel adds to the sum only at or above the threshold.
    function int unsigned gated(bit [7:0] v);
      return (v >= threshold) ? 32'(v) : 0;
    endfunction

    // Register write as seen at the access phase; unknown indexes do nothing.
    function void write_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        REG_THRESHOLD: threshold  = data[7:0];
        REG_WIDTH:     width_reg  = data[10:0];
        REG_HEIGHT:    height_reg = data[12:0];
        default: ;
      endcase
    endfunction

    // Advance the window by one accepted pixel and queue its result, if any.
    function void note_pixel(bit [7:0] pix);
      int unsigned    w, h, idx, acc;
      bit [7:0]       top, mid;
      bit             row_last, last_row;
      window_result_t res;
      w        = bounded(32'(width_reg), 3, LINE_DEPTH);
      h        = bounded(32'(height_reg), 3, ROW_LIMIT);
      idx      = (column_count < LINE_DEPTH) ? column_count : LINE_DEPTH - 1;
      top      = upper_line[idx];
      mid      = middle_line[idx];
      row_last = (column_count >= w - 1);
      last_row = (row_count >= h - 1);
      pixels_taken++;

      // Only interior centers produce a result.
      if (row_count >= 2 && column_count >= 2) begin
        acc = gated(top) + gated(mid) + gated(pix);
        foreach (cells[k]) acc += gated(cells[k]);
        res.window_sum = 12'(acc);
        res.center_row = 12'(row_count - 1);
        res.center_col = 10'(column_count - 1);
        res.frame_end  = row_last && last_row;
        predicted_windows.insert(predicted_windows.size(), res);
      end

      // Shift the line stores and the window cells.
      upper_line[idx]  = mid;
      middle_line[idx] = pix;
      cells[0] = cells[3];
      cells[1] = cells[4];
      cells[2] = cells[5];
      cells[3] = top;
      cells[4] = mid;
      cells[5] = pix;

      // Raster counters wrap at row and frame ends.
      if (row_last) begin
        column_count = 0;
        row_count    = last_row ? 0 : row_count + 1;
      end else begin
        column_count++;
      end
    endfunction

    // Compare one result transfer with the oldest prediction.
    function void check_result(logic [11:0] sum, logic [11:0] row, logic [9:0] col,
                               logic fend);
      window_result_t want;
      if (predicted_windows.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, sum %0d row %0d col %0d end %0b",
                 $time, sum, row, col, fend);
        return;
      end
      want = predicted_windows.pop_front();
      if (sum !== want.window_sum) begin
        errors++;
        $display("%0t: window_sum expected %0d actual %0d", $time, want.window_sum, sum);
      end
      if (row !== want.center_row) begin
        errors++;
        $display("%0t: center_row expected %0d actual %0d", $time, want.center_row, row);
      end
      if (col !== want.center_col) begin
        errors++;
        $display("%0t: center_col expected %0d actual %0d", $time, want.center_col, col);
      end
      if (fend !== want.frame_end) begin
        errors++;
        $display("%0t: frame_end expected %0b actual %0b", $time, want.frame_end, fend);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  pixel;
  logic        out_valid;
  logic        out_ready;
  logic [11:0] window_sum;
  logic [11:0] center_row;
  logic [9:0]  center_col;
  logic        frame_end;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  window_scoreboard sb;
  bit               send_burst;
  bit               take_burst;

  thresholded_window_sum_3x3_top #(
    .MAX_WIDTH(LINE_DEPTH),
    .MAX_HEIGHT(ROW_LIMIT)
  ) DUT (.*);

  // Free-running clock, 20 ns period.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Random stimulus values, biased toward the extremes and the threshold.
  function automatic bit [7:0] random_threshold();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd1;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic bit [7:0] random_pixel();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      2: return sb.threshold;
      3: return sb.threshold - 8'd1;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Register write through the configuration port; unused bits get noise.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] data;
    data = $urandom();
    case (idx)
      REG_THRESHOLD: data[7:0]  = value[7:0];
      REG_WIDTH:     data[10:0] = value[10:0];
      REG_HEIGHT:    data[12:0] = value[12:0];
      default:       data       = value;
    endcase
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  // One pixel transfer after a random gap; valid stays up into the next call.
  task automatic send_pixel(input bit [7:0] value);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel    <= value;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_pixel(value);
  endtask

  // Stop the pixel stream and wait until the block has gone quiet.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.predicted_windows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_pattern(input bit [7:0] pat [9]);
    foreach (pat[i]) send_pixel(pat[i]);
    settle();
  endtask

  // Random register change, used in mid-frame; widths stay within the
  // line-store columns that already hold pixels.
  task automatic shuffle_reg();
    case ($urandom_range(0, 3))
      0: write_reg(REG_THRESHOLD, 32'(random_threshold()));
      1: write_reg(REG_WIDTH, ($urandom_range(0, 15) == 0) ?
                   $urandom_range(0, 2) : $urandom_range(3, WARM_WIDTH));
      2: write_reg(REG_HEIGHT, $urandom_range(0, 6));
      default: write_reg(REG_UNUSED, $urandom());
    endcase
  endtask

  // Random pixels until the raster counters wrap back to the frame start.
  task automatic send_frame(input bit shuffle_regs);
    do begin
      send_pixel(random_pixel());
      if (shuffle_regs && $urandom_range(0, 31) == 0) begin
        settle();
        shuffle_reg();
      end
    end while (sb.row_count != 0 || sb.column_count != 0);
    settle();
  endtask

  // Result side: random ready gaps, bursts, and an occasional long hold-off.
  initial begin : result_sink
    int unsigned gap;
    int unsigned taken;
    out_ready  <= 1'b0;
    take_burst = 1'b0;
    taken      = 0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) take_burst = !take_burst;
      gap = take_burst ? 0 : $urandom_range(0, 5);
      if (taken == 100 || taken % 500 == 499) gap = HOLD_CYCLES;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      sb.check_result(window_sum, center_row, center_col, frame_end);
      taken++;
    end
  end

  // Watchdog on cycles without any transfer.
  initial begin : stall_watch
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst === 1'b1 || (in_valid === 1'b1 && in_ready === 1'b1) ||
          (out_valid === 1'b1 && out_ready === 1'b1) ||
          (psel === 1'b1 && penable === 1'b1 && pready === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Main sequence: reset, directed frames, line-store fill, random frames.
  initial begin : stimulus
    bit [7:0]    pat_mixed [9];
    bit [7:0]    pat_full [9];
    bit [7:0]    pat_edge [9];
    int unsigned start;
    sb         = new();
    rst        = 1'b1;
    in_valid   = 1'b0;
    pixel      = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    send_burst = 1'b0;
    pat_mixed  = '{8'd255, 8'd0, 8'd255, 8'd254, 8'd255, 8'd0, 8'd1, 8'd255, 8'd128};
    pat_full   = '{default: 8'd255};
    pat_edge   = '{8'd127, 8'd128, 8'd129, 8'd0, 8'd255, 8'd128, 8'd127, 8'd200, 8'd1};
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset threshold, smallest frame, and a write to an unused address.
    write_reg(REG_WIDTH, 3);
    write_reg(REG_HEIGHT, 3);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    send_pattern(pat_mixed);

    // Threshold zero counts every pixel; undersized geometry saturates to 3.
    write_reg(REG_THRESHOLD, 0);
    write_reg(REG_WIDTH, 0);
    write_reg(REG_HEIGHT, 2);
    send_pattern(pat_full);

    // Pixels right at and around the threshold.
    write_reg(REG_THRESHOLD, 128);
    write_reg(REG_WIDTH, 1);
    write_reg(REG_HEIGHT, 1);
    send_pattern(pat_edge);

    // One frame at the widest random width fills those columns of both stores.
    write_reg(REG_THRESHOLD, 32'(random_threshold()));
    write_reg(REG_WIDTH, WARM_WIDTH);
    write_reg(REG_HEIGHT, 3);
    send_frame(1'b0);

    // Small random frames, some with register changes in mid-frame.
    start = sb.pixels_taken;
    while (sb.pixels_taken - start < RANDOM_PIXELS) begin
      write_reg(REG_THRESHOLD, 32'(random_threshold()));
      write_reg(REG_WIDTH, ($urandom_range(0, 7) == 0) ?
                $urandom_range(0, 2) : $urandom_range(3, WARM_WIDTH));
      write_reg(REG_HEIGHT, ($urandom_range(0, 7) == 0) ?
                $urandom_range(0, 2) : $urandom_range(3, 6));
      send_frame($urandom_range(0, 2) == 0);
    end

    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
